[rtl/urte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urte_pkg
// Shared types and constants of the uart ring buffer engine: request codes,
// request and result items, ring sizing defaults.
// ----------------------------------------------------------------------------
package urte_pkg;

    localparam int BYTE_W          = 8;
    localparam int RX_ENTRY_W      = BYTE_W + 3;
    localparam int RING_DEPTH_DEF  = 256;

    localparam logic [1:0] REQ_HOST_WRITE = 2'd0;
    localparam logic [1:0] REQ_HOST_READ  = 2'd1;
    localparam logic [1:0] REQ_PORT_RECV  = 2'd2;
    localparam logic [1:0] REQ_PORT_DRAIN = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] data_byte;
        logic              rx_overrun;
        logic              rx_framing;
        logic              rx_parity;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] read_data;
        logic              read_overrun;
        logic              read_framing;
        logic              read_parity;
        logic              ring_overflow_report;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic              drain_enabled;
    } t_out_item;

endpackage

[rtl/urte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urte_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module urte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/uart_rx_tx_fifo_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_fifo_engine
// Transmit and receive byte rings between a host and a serial port, each
// ring in its own ram, keeping one slot free (RING_DEPTH-1 items each).
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, i_item              taken when start high and busy low
//  result    o_done, o_result           one cycle strobe, cannot be stalled
//
//  pushes, rejected requests and overflow reports: result in the cycle after
//  the request is taken, busy stays low
//  pops from either ring: the ram read data is registered, then the result
//  is registered, busy high for one cycle in between
//  synchronous active low reset empties both rings and clears the flags
//  the ram contents are not cleared; pops only see slots already pushed
// ----------------------------------------------------------------------------
module uart_rx_tx_fifo_engine #(
    parameter int RING_DEPTH = urte_pkg::RING_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  urte_pkg::t_in_item  i_item,
    output logic                o_done,
    output urte_pkg::t_out_item o_result
);

    import urte_pkg::*;

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    t_state          r_state, n_state;
    logic [PW-1:0]   r_rx_head, n_rx_head;
    logic [PW-1:0]   r_rx_tail, n_rx_tail;
    logic [PW-1:0]   r_tx_head, n_tx_head;
    logic [PW-1:0]   r_tx_tail, n_tx_tail;
    logic            r_sticky, n_sticky;
    logic            r_drain, n_drain;
    logic            r_pop_rx, n_pop_rx;
    logic            r_done, n_done;
    t_out_item       r_result, n_result;

    logic                  take;
    logic                  tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0]     tx_rdata;
    logic [RX_ENTRY_W-1:0] rx_rdata, rx_wdata;

    assign take     = start && (r_state == S_IDLE);
    assign rx_wdata = {i_item.rx_parity, i_item.rx_framing, i_item.rx_overrun,
                       i_item.data_byte};

    always_comb begin
        n_state   = r_state;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_sticky  = r_sticky;
        n_drain   = r_drain;
        n_pop_rx  = r_pop_rx;
        n_done    = 1'b0;
        n_result  = '0;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        rx_we     = 1'b0;
        rx_re     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_done = 1'b1;
                    unique case (i_item.req_type)
                        REQ_HOST_WRITE: begin
                            if (ptr_next(r_tx_head) != r_tx_tail) begin
                                tx_we     = 1'b1;
                                n_tx_head = ptr_next(r_tx_head);
                                n_drain   = 1'b1;
                                n_result.accepted = 1'b1;
                            end
                        end
                        REQ_HOST_READ: begin
                            if (r_sticky) begin
                                n_sticky = 1'b0;
                                n_result.accepted             = 1'b1;
                                n_result.read_overrun         = 1'b1;
                                n_result.ring_overflow_report = 1'b1;
                            end else if (r_rx_tail != r_rx_head) begin
                                // result comes out after the ram read
                                rx_re     = 1'b1;
                                n_rx_tail = ptr_next(r_rx_tail);
                                n_pop_rx  = 1'b1;
                                n_done    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        REQ_PORT_RECV: begin
                            if (ptr_next(r_rx_head) == r_rx_tail) begin
                                n_sticky = 1'b1;
                            end else begin
                                rx_we     = 1'b1;
                                n_rx_head = ptr_next(r_rx_head);
                            end
                        end
                        REQ_PORT_DRAIN: begin
                            if (r_tx_tail == r_tx_head) begin
                                n_drain = 1'b0;
                            end else begin
                                tx_re     = 1'b1;
                                n_tx_tail = ptr_next(r_tx_tail);
                                n_pop_rx  = 1'b0;
                                n_done    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        default: ;
                    endcase
                    n_result.drain_enabled = n_drain;
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_pop_rx) begin
                    n_result.accepted     = 1'b1;
                    n_result.read_data    = rx_rdata[BYTE_W-1:0];
                    n_result.read_overrun = rx_rdata[BYTE_W];
                    n_result.read_framing = rx_rdata[BYTE_W+1];
                    n_result.read_parity  = rx_rdata[BYTE_W+2];
                end else begin
                    n_result.tx_valid = 1'b1;
                    n_result.tx_data  = tx_rdata;
                end
                n_result.drain_enabled = r_drain;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_sticky  <= 1'b0;
            r_drain   <= 1'b0;
            r_pop_rx  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_sticky  <= n_sticky;
            r_drain   <= n_drain;
            r_pop_rx  <= n_pop_rx;
            r_done    <= n_done;
        end
        r_result <= n_result;
    end

    urte_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (i_item.data_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    urte_ram #(
        .WIDTH (RX_ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (rx_wdata),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
